// ===== sv/mntm_pkg.sv =====
// ----------------------------------------------------------------------------
// mntm_pkg
// Shared types and constants for the MIDI note transform mapper.
// ----------------------------------------------------------------------------
package mntm_pkg;

  localparam int MNTM_VOICES = 32;

  localparam int CHAN_W = 4;
  localparam int NOTE_W = 7;
  localparam int KEY_W  = CHAN_W + NOTE_W;

  // One voice: (channel, input note) -> output note
  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] chan;
    logic [NOTE_W-1:0] in_note;
    logic [NOTE_W-1:0] out_note;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SHIFT
  } cell_op_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic              hit;
    logic [KEY_W-1:0]  key;
    logic [NOTE_W-1:0] out_note;
  } cell_ctrl_t;

endpackage

// ===== sv/mntm_cell.sv =====
// ----------------------------------------------------------------------------
// mntm_cell
// One slot of the sorted voice chain. Holds one entry, compares it against
// the broadcast key, and takes its own, the new, or a neighbor's entry.
// ----------------------------------------------------------------------------
module mntm_cell
  import mntm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     left_ent,
  input  logic       left_gt,
  input  entry_t     right_ent,
  output entry_t     ent,
  output logic       eq,
  output logic       gt
);

  logic [KEY_W-1:0] own_key;

  assign own_key = {ent.chan, ent.in_note};

  // Flags are registered, and the update acts on the registered flags.
  always_ff @(posedge clk) begin
    eq <= ent.valid && (own_key == ctrl.key);
    gt <= !ent.valid || (own_key > ctrl.key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_INSERT: begin
          if (ctrl.hit) begin
            if (eq) ent.out_note <= ctrl.out_note;
          end else if (gt) begin
            if (left_gt) begin
              ent <= left_ent;
            end else begin
              ent.valid    <= 1'b1;
              ent.chan     <= ctrl.key[KEY_W-1:NOTE_W];
              ent.in_note  <= ctrl.key[NOTE_W-1:0];
              ent.out_note <= ctrl.out_note;
            end
          end
        end
        // everything from the matching slot on moves up one place
        CELL_DELETE: begin
          if (eq || gt) ent <= right_ent;
        end
        CELL_SHIFT: begin
          ent <= right_ent;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/mntm_pitch.sv =====
// ----------------------------------------------------------------------------
// mntm_pitch
// Note-on pitch transform: mirror about pivot, octave wrap, clamp. Registered.
// ----------------------------------------------------------------------------
module mntm_pitch
  import mntm_pkg::*;
(
  input  logic              clk,
  input  logic [NOTE_W-1:0] note_in,
  input  logic [NOTE_W-1:0] pivot,
  input  logic              invert,
  input  logic [1:0]        wrap,
  output logic [NOTE_W-1:0] note_out
);

  // d mod 12 for d < 256: floor(d/12) == (d*171) >> 11 over that range
  function automatic logic [3:0] mod12(input logic [7:0] d);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  qx12;
    prod = 16'(d) * 16'd171;
    q    = prod[15:11];
    qx12 = 8'(q) * 8'd12;
    return 4'(d - qx12);
  endfunction

  logic signed [9:0] p, x, span, lo, hi, xw;
  logic        [7:0] d_lo, d_hi;
  logic        [3:0] r_lo, r_hi;
  logic signed [9:0] adj_lo, adj_hi;

  always_comb begin
    p = 10'(pivot);
    if (p < 10'sd24) p = 10'sd24;
    if (p > 10'sd96) p = 10'sd96;
    x      = invert ? (10'(p <<< 1) - 10'(note_in)) : 10'(note_in);
    span   = 10'(wrap) * 10'sd12;
    lo     = p - span;
    hi     = p + span;
    d_lo   = 8'(lo - x);
    d_hi   = 8'(x - hi);
    r_lo   = mod12(d_lo);
    r_hi   = mod12(d_hi);
    adj_lo = (r_lo == 4'd0) ? 10'sd0 : (10'sd12 - 10'(r_lo));
    adj_hi = (r_hi == 4'd0) ? 10'sd0 : (10'sd12 - 10'(r_hi));
    xw = x;
    if (wrap != 2'd0) begin
      if (x < lo)      xw = lo + adj_lo;
      else if (x > hi) xw = hi - adj_hi;
    end
    if (xw < 10'sd0)   xw = 10'sd0;
    if (xw > 10'sd127) xw = 10'sd127;
  end

  always_ff @(posedge clk) begin
    note_out <= xw[NOTE_W-1:0];
  end

endmodule

// ===== sv/midi_note_transform_mapper_core.sv =====
// ----------------------------------------------------------------------------
// midi_note_transform_mapper_core
// MIDI note transform with a voice table kept as a sorted chain of cells.
// ----------------------------------------------------------------------------
// After a MIDI word is accepted it goes through S_CMP, in which every cell
// compares its (channel, note) key against the word, and S_EXEC, in which
// the chain updates and the result is loaded into the output register; it
// waits there only if the output register is still occupied. The input is
// ready again in the cycle after that, so a new word is taken only once the
// last one has left S_EXEC. A flush emits one note-off per held voice per
// cycle while the output register is free, lowest (channel, note) first, and
// ends once the table is empty; an empty table gives no word. The chain is
// cleared by reset, and the block accepts a word right after reset.
module midi_note_transform_mapper_core
  import mntm_pkg::*;
#(
  parameter int VOICES = MNTM_VOICES
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [6:0]  cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // status_byte, data_one, data_two, sample_pos
  input  logic        s_tuser,   // opcode
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_status, out_data_one, out_data_two,
                                 // out_sample_pos
  output logic        m_tuser,   // mapping_lost
  output logic        m_tlast
);

  localparam logic [2:0] REG_BYPASS     = 3'd0;
  localparam logic [2:0] REG_INV_PITCH  = 3'd1;
  localparam logic [2:0] REG_PIVOT      = 3'd2;
  localparam logic [2:0] REG_WRAP       = 3'd3;
  localparam logic [2:0] REG_INV_VEL    = 3'd4;

  localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON   = 4'h9;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC, S_FLUSH} state_t;

  state_t state;

  logic       bypass, invert_pitch, invert_velocity;
  logic [6:0] pivot_note;
  logic [1:0] wrap_mode;

  // held word
  logic [7:0]  st;
  logic [6:0]  d1, d2;
  logic [15:0] pos;

  // chain
  cell_ctrl_t          ctrl;
  entry_t              ent       [VOICES];
  entry_t              left_ent  [VOICES];
  entry_t              right_ent [VOICES];
  logic [VOICES-1:0]   eq, gt, left_gt;

  logic [NOTE_W-1:0] pitch_note;
  logic [NOTE_W-1:0] hit_note;
  logic              hit, full, out_free, out_load;
  logic              is_on, is_off;
  logic [6:0]        vel;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free &&
                    ((state == S_EXEC) || (state == S_FLUSH && ent[0].valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass          <= 1'b0;
      invert_pitch    <= 1'b1;
      pivot_note      <= 7'd60;
      wrap_mode       <= 2'd0;
      invert_velocity <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BYPASS:    bypass          <= cfg_wdata[0];
        REG_INV_PITCH: invert_pitch    <= cfg_wdata[0];
        REG_PIVOT:     pivot_note      <= cfg_wdata;
        REG_WRAP:      wrap_mode       <= cfg_wdata[1:0];
        REG_INV_VEL:   invert_velocity <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  mntm_pitch u_pitch (
    .clk      (clk),
    .note_in  (d1),
    .pivot    (pivot_note),
    .invert   (invert_pitch),
    .wrap     (wrap_mode),
    .note_out (pitch_note)
  );

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_ent[g] = '0;
      assign left_gt[g]  = 1'b0;
    end else begin : g_mid
      assign left_ent[g] = ent[g-1];
      assign left_gt[g]  = gt[g-1];
    end
    if (g == VOICES-1) begin : g_tail
      assign right_ent[g] = '0;
    end else begin : g_body
      assign right_ent[g] = ent[g+1];
    end

    mntm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left_ent  (left_ent[g]),
      .left_gt   (left_gt[g]),
      .right_ent (right_ent[g]),
      .ent       (ent[g]),
      .eq        (eq[g]),
      .gt        (gt[g])
    );
  end

  assign hit  = |eq;
  assign full = ent[VOICES-1].valid;

  always_comb begin
    hit_note = '0;
    for (int i = 0; i < VOICES; i++) begin
      hit_note = hit_note | (eq[i] ? ent[i].out_note : '0);
    end
  end

  assign is_on  = !bypass && (st[7:4] == KIND_NOTE_ON) && (d2 != 7'd0);
  assign is_off = !bypass && !is_on &&
                  ((st[7:4] == KIND_NOTE_OFF) || (st[7:4] == KIND_NOTE_ON));
  // note-on velocity is never 0 here, so 128 - v stays in 1..127
  assign vel    = invert_velocity ? 7'(8'd128 - 8'(d2)) : d2;

  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.hit      = hit;
    ctrl.key      = {st[3:0], d1};
    ctrl.out_note = pitch_note;
    if (state == S_EXEC && out_free) begin
      if (is_on && (hit || !full)) ctrl.op = CELL_INSERT;
      else if (is_off && hit)      ctrl.op = CELL_DELETE;
    end else if (state == S_FLUSH && out_free && ent[0].valid) begin
      ctrl.op = CELL_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st  <= s_tdata[7:0];
      d1  <= s_tdata[14:8];
      d2  <= s_tdata[21:15];
      pos <= s_tdata[37:22];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= s_tuser ? S_FLUSH : S_CMP;
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            m_tlast <= 1'b1;
            m_tuser <= is_on && !hit && full;
            if (is_on) begin
              m_tdata <= {2'b00, pos, vel, pitch_note, st};
            end else if (is_off && hit) begin
              m_tdata <= {2'b00, pos, d2, hit_note, KIND_NOTE_OFF, st[3:0]};
            end else begin
              m_tdata <= {2'b00, pos, d2, d1, st};
            end
            state <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!ent[0].valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_tlast  <= !right_ent[0].valid;
            m_tuser  <= 1'b0;
            m_tdata  <= {2'b00, 16'd0, 7'd0, ent[0].out_note,
                         KIND_NOTE_OFF, ent[0].chan};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/mntm_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// mntm_tb_pkg
// Register indexes, opcodes and MIDI message kinds shared by the testbench.
// ----------------------------------------------------------------------------
package mntm_tb_pkg;

  localparam logic [2:0] REG_BYPASS       = 3'd0;
  localparam logic [2:0] REG_INVERT_PITCH = 3'd1;
  localparam logic [2:0] REG_PIVOT_NOTE   = 3'd2;
  localparam logic [2:0] REG_WRAP_MODE    = 3'd3;
  localparam logic [2:0] REG_INVERT_VEL   = 3'd4;

  localparam logic OP_MIDI  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // upper nibble of the status byte
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

endpackage

// ===== tb/sv/midi_map_checker.sv =====
// ----------------------------------------------------------------------------
// midi_map_checker
// Watches the config port and both streams, keeps its own voice table and
// register copies, predicts every output word and compares field by field.
// ----------------------------------------------------------------------------
module midi_map_checker
  import mntm_pkg::*;
  import mntm_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // status_byte, data_one, data_two, sample_pos
  input  logic        s_tuser,   // opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // out_status, out_data_one, out_data_two,
                                 // out_sample_pos
  input  logic        m_tuser,   // mapping_lost
  input  logic        m_tlast,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    logic [7:0]  status;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] pos;
    logic        lost;
    logic        last;
  } midi_word_t;

  entry_t     voices [MNTM_VOICES];
  logic       bypass_r;
  logic       inv_pitch_r;
  logic [6:0] pivot_r;
  logic [1:0] wrap_r;
  logic       inv_vel_r;
  midi_word_t expected_words [$];
  int         errors = 0;

  assign mismatches = errors;

  function automatic logic [6:0] mapped_note(input logic [6:0] note);
    int p;
    int n;
    int x;
    int span;
    p = int'(pivot_r);
    n = int'(note);
    if (p < 24) p = 24;
    if (p > 96) p = 96;
    x = inv_pitch_r ? 2 * p - n : n;
    if (wrap_r != 2'd0) begin
      span = 12 * int'(wrap_r);
      while (x < p - span) x += 12;
      while (x > p + span) x -= 12;
    end
    if (x < 0) x = 0;
    if (x > 127) x = 127;
    return x[6:0];
  endfunction

  task automatic push_word(input logic [7:0] st, input logic [6:0] d1,
                           input logic [6:0] d2, input logic [15:0] pos,
                           input logic lost, input logic last);
    midi_word_t w;
    w.status   = st;
    w.note     = d1;
    w.velocity = d2;
    w.pos      = pos;
    w.lost     = lost;
    w.last     = last;
    expected_words.push_back(w);
  endtask

  task automatic transform_word(input logic op, input logic [39:0] data);
    logic [7:0]  st;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [15:0] pos;
    logic [3:0]  ch;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [7:0]  flipped;
    int          slot;
    int          prev;
    int          best;
    int          bkey;
    int          key;
    int          first;
    st  = data[7:0];
    d1  = data[14:8];
    d2  = data[21:15];
    pos = data[37:22];
    ch  = st[3:0];

    if (op == OP_FLUSH) begin
      // one note-off per held voice, ascending (channel, input note)
      first = expected_words.size();
      prev  = -1;
      do begin
        best = -1;
        bkey = 0;
        for (int i = 0; i < MNTM_VOICES; i++) begin
          if (voices[i].valid) begin
            key = int'({voices[i].chan, voices[i].in_note});
            if (key > prev && (best < 0 || key < bkey)) begin
              best = i;
              bkey = key;
            end
          end
        end
        if (best >= 0) begin
          push_word({KIND_NOTE_OFF, voices[best].chan}, voices[best].out_note,
                    7'd0, 16'd0, 1'b0, 1'b0);
          prev = bkey;
        end
      end while (best >= 0);
      if (expected_words.size() > first)
        expected_words[expected_words.size() - 1].last = 1'b1;
      for (int i = 0; i < MNTM_VOICES; i++) voices[i].valid = 1'b0;
    end else if (!bypass_r && st[7:4] == KIND_NOTE_ON && d2 != 7'd0) begin
      note    = mapped_note(d1);
      flipped = 8'd128 - {1'b0, d2};
      vel     = inv_vel_r ? flipped[6:0] : d2;
      slot    = -1;
      for (int i = 0; i < MNTM_VOICES; i++) begin
        if (voices[i].valid && voices[i].chan == ch && voices[i].in_note == d1) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < MNTM_VOICES; i++) begin
          if (!voices[i].valid) begin
            slot = i;
            break;
          end
        end
      end
      if (slot >= 0) begin
        voices[slot].valid    = 1'b1;
        voices[slot].chan     = ch;
        voices[slot].in_note  = d1;
        voices[slot].out_note = note;
      end
      push_word(st, note, vel, pos, slot < 0, 1'b1);
    end else if (!bypass_r && (st[7:4] == KIND_NOTE_OFF || st[7:4] == KIND_NOTE_ON)) begin
      slot = -1;
      for (int i = 0; i < MNTM_VOICES; i++) begin
        if (voices[i].valid && voices[i].chan == ch && voices[i].in_note == d1) begin
          slot = i;
          break;
        end
      end
      if (slot >= 0) begin
        push_word({KIND_NOTE_OFF, ch}, voices[slot].out_note, d2, pos, 1'b0, 1'b1);
        voices[slot].valid = 1'b0;
      end else begin
        push_word(st, d1, d2, pos, 1'b0, 1'b1);
      end
    end else begin
      push_word(st, d1, d2, pos, 1'b0, 1'b1);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic compare_word();
    midi_word_t want;
    if (expected_words.size() == 0) begin
      $error("output word with nothing expected: tdata %h", m_tdata);
      errors++;
    end else begin
      want = expected_words.pop_front();
      check_field("out_status",     32'(want.status),   32'(m_tdata[7:0]));
      check_field("out_data_one",   32'(want.note),     32'(m_tdata[14:8]));
      check_field("out_data_two",   32'(want.velocity), 32'(m_tdata[21:15]));
      check_field("out_sample_pos", 32'(want.pos),      32'(m_tdata[37:22]));
      check_field("mapping_lost",   32'(want.lost),     32'(m_tuser));
      check_field("last",           32'(want.last),     32'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MNTM_VOICES; i++) voices[i] = '0;
      bypass_r    = 1'b0;
      inv_pitch_r = 1'b1;
      pivot_r     = 7'd60;
      wrap_r      = 2'd0;
      inv_vel_r   = 1'b0;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) compare_word();
      if (cfg_we) begin
        case (cfg_addr)
          REG_BYPASS:       bypass_r    = cfg_wdata[0];
          REG_INVERT_PITCH: inv_pitch_r = cfg_wdata[0];
          REG_PIVOT_NOTE:   pivot_r     = cfg_wdata;
          REG_WRAP_MODE:    wrap_r      = cfg_wdata[1:0];
          REG_INVERT_VEL:   inv_vel_r   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) transform_word(s_tuser, s_tdata);
    end
    outstanding <= expected_words.size();
  end

endmodule

// ===== tb/sv/midi_note_transform_mapper_core_tb.sv =====
// ----------------------------------------------------------------------------
// midi_note_transform_mapper_core_tb
// Drives MIDI words, flushes and register writes into the note mapper with
// random stalls on both streams; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module midi_note_transform_mapper_core_tb;
  import mntm_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE         = 6;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [6:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          mismatches;
  int          outstanding;
  bit          src_stalls = 1'b1;
  bit          sink_stalls = 1'b1;
  logic [10:0] held_keys [$];   // {channel, note} of note-ons not yet released

  always #5 clk = ~clk;

  midi_note_transform_mapper_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  midi_map_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  task automatic send_word(input logic op, input logic [7:0] st, input logic [6:0] d1,
                           input logic [6:0] d2, input logic [15:0] pos);
    s_tuser  <= op;
    s_tdata  <= {2'b00, pos, d2, d1, st};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (src_stalls && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // hold off the sender until every predicted word is out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic byp, input logic inv_p, input logic [6:0] piv,
                            input logic [1:0] wrap, input logic inv_v);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BYPASS;
    cfg_wdata <= {6'd0, byp};
    @(posedge clk);
    cfg_addr  <= REG_INVERT_PITCH;
    cfg_wdata <= {6'd0, inv_p};
    @(posedge clk);
    cfg_addr  <= REG_PIVOT_NOTE;
    cfg_wdata <= piv;
    @(posedge clk);
    cfg_addr  <= REG_WRAP_MODE;
    cfg_wdata <= {5'd0, wrap};
    @(posedge clk);
    cfg_addr  <= REG_INVERT_VEL;
    cfg_wdata <= {6'd0, inv_v};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_config(input int bypass_pct);
    logic [6:0] piv;
    case ($urandom_range(0, 5))
      0:       piv = 7'd0;
      1:       piv = 7'd24;
      2:       piv = 7'd96;
      3:       piv = 7'd127;
      default: piv = 7'($urandom_range(24, 96));
    endcase
    set_config($urandom_range(0, 99) < bypass_pct, 1'($urandom_range(0, 1)), piv,
               2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  // mostly well-formed on/off pairs, plus stray messages and flushes
  task automatic send_random_word(input int on_pct, input int flush_pct);
    int          pick;
    int          idx;
    logic [3:0]  ch;
    logic [6:0]  note;
    logic [10:0] key;
    logic [15:0] pos;
    pick = $urandom_range(0, 99);
    ch   = 4'($urandom_range(0, 15));
    note = 7'($urandom_range(0, 127));
    pos  = 16'($urandom_range(0, 65535));
    if (pick < on_pct) begin
      send_word(OP_MIDI, {KIND_NOTE_ON, ch}, note, 7'($urandom_range(1, 127)), pos);
      held_keys.push_back({ch, note});
    end else if (pick < on_pct + (100 - on_pct - flush_pct) / 2 && held_keys.size() > 0) begin
      idx = $urandom_range(0, held_keys.size() - 1);
      key = held_keys[idx];
      held_keys.delete(idx);
      if ($urandom_range(0, 1))
        send_word(OP_MIDI, {KIND_NOTE_OFF, key[10:7]}, key[6:0],
                  7'($urandom_range(0, 127)), pos);
      else
        send_word(OP_MIDI, {KIND_NOTE_ON, key[10:7]}, key[6:0], 7'd0, pos);
    end else if (pick < 100 - flush_pct) begin
      if ($urandom_range(0, 2) == 0)
        send_word(OP_MIDI, {KIND_NOTE_OFF, ch}, note, 7'($urandom_range(0, 127)), pos);
      else
        send_word(OP_MIDI, 8'($urandom_range(0, 255)), note,
                  7'($urandom_range(0, 127)), pos);
    end else begin
      send_word(OP_FLUSH, 8'($urandom_range(0, 255)), note,
                7'($urandom_range(0, 127)), pos);
      held_keys.delete();
    end
  endtask

  initial begin : sink_ready
    int hold;
    hold = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 11) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_BYPASS;
    cfg_wdata <= 7'd0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_MIDI;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: mirror about 60, no wrap
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h0}, 7'd0, 7'd127, 16'hffff);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'hf}, 7'd127, 7'd1, 16'h0000);  // clamps low
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h0}, 7'd0, 7'd64, 16'h1234);   // same key again
    send_word(OP_MIDI, {KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd127, 16'h0001); // hit
    send_word(OP_MIDI, {KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd0, 16'h0002);   // miss
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'hf}, 7'd127, 7'd0, 16'h0003);  // zero-velocity off
    send_word(OP_MIDI, 8'hb3, 7'd127, 7'd127, 16'h0004);
    send_word(OP_MIDI, 8'h00, 7'd0, 7'd0, 16'h0005);
    send_word(OP_MIDI, 8'hff, 7'd127, 7'd127, 16'h0006);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h5}, 7'd60, 7'd100, 16'h0007);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h2}, 7'd10, 7'd5, 16'h0008);
    send_word(OP_FLUSH, 8'hff, 7'd127, 7'd127, 16'hffff);
    send_word(OP_FLUSH, 8'h00, 7'd0, 7'd0, 16'h0000);                  // empty table
    drain();

    // pivot above range, widest wrap, velocity flip
    set_config(1'b0, 1'b0, 7'd127, 2'd3, 1'b1);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h1}, 7'd0, 7'd1, 16'h0009);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h1}, 7'd127, 7'd127, 16'h000a);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'ha}, 7'd64, 7'd64, 16'h000b);
    drain();

    // pivot below range, narrowest wrap
    set_config(1'b0, 1'b1, 7'd0, 2'd1, 1'b0);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h3}, 7'd127, 7'd90, 16'h000c);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h3}, 7'd0, 7'd90, 16'h000d);
    drain();

    // bypass leaves the table alone, flush still drains it
    set_config(1'b1, 1'b1, 7'd60, 2'd2, 1'b1);
    send_word(OP_MIDI, {KIND_NOTE_ON, 4'h1}, 7'd0, 7'd50, 16'h000e);
    send_word(OP_MIDI, {KIND_NOTE_OFF, 4'h1}, 7'd0, 7'd0, 16'h000f);
    send_word(OP_FLUSH, 8'h5a, 7'd33, 7'd66, 16'habcd);
    drain();
    held_keys.delete();

    random_config(10);
    repeat (35) send_random_word(45, 4);
    drain();

    // overfill the voice table, then flush a full one
    random_config(0);
    repeat (45) send_random_word(85, 0);
    send_word(OP_FLUSH, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)));
    held_keys.delete();
    drain();

    random_config(0);
    src_stalls = 1'b0;
    repeat (20) send_random_word(45, 4);
    drain();
    src_stalls = 1'b1;
    repeat (15) send_random_word(45, 4);
    drain();

    random_config(100);
    sink_stalls = 1'b0;
    repeat (25) send_random_word(45, 4);
    drain();

    // closing stretch at full rate on both sides
    random_config(20);
    src_stalls  = 1'b0;
    sink_stalls = 1'b0;
    repeat (28) send_random_word(50, 3);
    send_word(OP_FLUSH, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)));
    drain();

    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mntm_pkg.sv
sv/mntm_cell.sv
sv/mntm_pitch.sv
sv/midi_note_transform_mapper_core.sv
tb/sv/mntm_tb_pkg.sv
tb/sv/midi_map_checker.sv
tb/sv/midi_note_transform_mapper_core_tb.sv
